FILE: src/sssf_pkg.sv
// ----------------------------------------------------------------------------
// sssf_pkg
// Shared types, constants and glyph decoder for the seven-segment formatter.
// ----------------------------------------------------------------------------
package sssf_pkg;

    localparam int DIGITS   = 4;
    localparam int CODE_W   = 4;
    localparam int BIN_W    = 14;                  // holds up to 9999
    localparam int BCD_W    = DIGITS * CODE_W;
    localparam int SCAN_W   = 2;
    localparam int SEG_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;
    localparam logic [CODE_W-1:0] ZERO_CODE  = 4'd0;
    localparam logic [BIN_W-1:0]  VALUE_SAT  = 14'd9999;
    localparam logic [DIGITS-1:0] TEMP_POINT = 4'b0100;  // point on digit 2
    localparam logic [DIGITS-1:0] NO_POINT   = 4'b0000;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_TEMP  = 2'd1,
        CMD_PRESS = 2'd2,
        CMD_PROBE = 2'd3
    } cmd_t;

    // One request travelling down the conversion chain.
    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [BCD_W-1:0]  bcd;
        logic [BIN_W-1:0]  bin;
    } item_t;

    // Digit code to segments g..a, active high; codes above 9 are dark.
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: src/sssf_if.sv
// ----------------------------------------------------------------------------
// sssf_if
// Valid/ready channels for requests into and results out of the formatter.
// ----------------------------------------------------------------------------
interface sssf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] temp_centi;
    logic [31:0]        pressure_hpa;

    modport source (output valid, output cmd, output temp_centi,
                    output pressure_hpa, input ready);
    modport sink   (input valid, input cmd, input temp_centi,
                    input pressure_hpa, output ready);
endinterface

interface sssf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] segments_n;
    logic       point_n;
    logic [3:0] digit_enable_n;

    modport source (output valid, output segments_n, output point_n,
                    output digit_enable_n, input ready);
    modport sink   (input valid, input segments_n, input point_n,
                    input digit_enable_n, output ready);
endinterface

FILE: src/sssf_front.sv
// ----------------------------------------------------------------------------
// sssf_front
// Entry stage: magnitude, saturation to 9999, and launch into the BCD chain.
// ----------------------------------------------------------------------------
module sssf_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          req_valid,
    input  logic [1:0]                    cmd,
    input  logic signed [sssf_pkg::DATA_W-1:0] temp_centi,
    input  logic [sssf_pkg::DATA_W-1:0]   pressure_hpa,
    output sssf_pkg::item_t               item
);
    import sssf_pkg::*;

    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] raw;
    logic [BIN_W-1:0]  value;
    item_t             item_reg;
    item_t             item_next;

    // Two's complement magnitude; the most negative value wraps to 2^31.
    assign mag = temp_centi[DATA_W-1] ? (~DATA_W'(temp_centi) + DATA_W'(1))
                                      : DATA_W'(temp_centi);

    assign raw   = (cmd_t'(cmd) == CMD_PRESS) ? pressure_hpa : mag;
    // Temperature saturation at 99.9 falls out of dropping the ones digit
    // of a 9999-saturated value.
    assign value = (raw > DATA_W'(VALUE_SAT)) ? VALUE_SAT : raw[BIN_W-1:0];

    always_comb
    begin
        item_next = item_reg;
        if (advance)
        begin
            item_next.valid = req_valid;
            item_next.cmd   = cmd_t'(cmd);
            item_next.bcd   = '0;
            item_next.bin   = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

FILE: src/sssf_dd_cell.sv
// ----------------------------------------------------------------------------
// sssf_dd_cell
// One double-dabble step: add-3 on large digits, shift in one binary bit.
// ----------------------------------------------------------------------------
module sssf_dd_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  sssf_pkg::item_t prev,
    output sssf_pkg::item_t item
);
    import sssf_pkg::*;

    logic [BCD_W-1:0] adj;
    item_t            item_reg;
    item_t            item_next;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (prev.bcd[d*CODE_W +: CODE_W] >= CODE_W'(5))
                adj[d*CODE_W +: CODE_W] = prev.bcd[d*CODE_W +: CODE_W] + CODE_W'(3);
            else
                adj[d*CODE_W +: CODE_W] = prev.bcd[d*CODE_W +: CODE_W];
        end
    end

    always_comb
    begin
        item_next = item_reg;
        if (advance)
        begin
            item_next.valid = prev.valid;
            item_next.cmd   = prev.cmd;
            item_next.bcd   = {adj[BCD_W-2:0], prev.bin[BIN_W-1]};
            item_next.bin   = {prev.bin[BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

FILE: src/sssf_display.sv
// ----------------------------------------------------------------------------
// sssf_display
// Display state, format commit, scan counter and result output register.
// ----------------------------------------------------------------------------
module sssf_display
(
    input  logic            clk,
    input  logic            rst_n,
    input  sssf_pkg::item_t item,
    output logic            advance,
    sssf_out_if.source      res
);
    import sssf_pkg::*;

    logic [CODE_W-1:0] codes_reg [DIGITS];
    logic [CODE_W-1:0] codes_next [DIGITS];
    logic [DIGITS-1:0] point_reg,  point_next;
    logic [SCAN_W-1:0] scan_reg,   scan_next;
    logic              valid_reg,  valid_next;
    logic [SEG_W-1:0]  seg_reg,    seg_next;
    logic              pt_reg,     pt_next;
    logic [DIGITS-1:0] en_reg,     en_next;

    // bcd digits, most significant first
    logic [CODE_W-1:0] thou, hund, tens, ones;

    assign thou = item.bcd[4*CODE_W-1:3*CODE_W];
    assign hund = item.bcd[3*CODE_W-1:2*CODE_W];
    assign tens = item.bcd[2*CODE_W-1:CODE_W];
    assign ones = item.bcd[CODE_W-1:0];

    assign advance = !valid_reg || res.ready;

    always_comb
    begin
        codes_next = codes_reg;
        point_next = point_reg;
        scan_next  = scan_reg;
        seg_next   = seg_reg;
        pt_next    = pt_reg;
        en_next    = en_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
            if (item.valid)
            begin
                unique case (item.cmd) inside
                    CMD_SCAN:
                    begin
                        valid_next = 1'b1;
                        seg_next   = ~glyph(codes_reg[scan_reg]);
                        pt_next    = ~point_reg[scan_reg];
                        en_next    = ~(DIGITS'(1) << scan_reg);
                        scan_next  = scan_reg + SCAN_W'(1);
                    end
                    CMD_TEMP, CMD_PROBE:
                    begin
                        codes_next[0] = (item.cmd == CMD_PROBE) ? ZERO_CODE : BLANK_CODE;
                        codes_next[1] = thou;
                        codes_next[2] = hund;
                        codes_next[3] = tens;
                        point_next    = TEMP_POINT;
                    end
                    CMD_PRESS:
                    begin
                        codes_next[0] = thou;
                        codes_next[1] = hund;
                        codes_next[2] = tens;
                        codes_next[3] = ones;
                        point_next    = NO_POINT;
                    end
                    default:
                    begin
                        valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
                codes_reg[i] <= BLANK_CODE;
            point_reg <= NO_POINT;
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            codes_reg <= codes_next;
            point_reg <= point_next;
            scan_reg  <= scan_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        pt_reg  <= pt_next;
        en_reg  <= en_next;
    end

    assign res.valid          = valid_reg;
    assign res.segments_n     = seg_reg;
    assign res.point_n        = pt_reg;
    assign res.digit_enable_n = en_reg;

endmodule

FILE: src/seven_segment_scan_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_formatter
// Four-digit multiplexed seven-segment driver with number formatting.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | per request
//  --------+-----+-------------------------------------------+-----------------
//  req     | in  | cmd, temp_centi, pressure_hpa             | every request
//  res     | out | segments_n, point_n, digit_enable_n       | scan ticks only
//
//  Throughput is one request per cycle while res is not stalled. Every
//  request walks the same 16-stage chain (entry stage, 14 double-dabble
//  cells, commit/output register), registered at each stage, so format
//  and scan requests keep their order. A stalled result on res holds the
//  whole chain, and req.ready drops with it. Reset clears all valid bits,
//  blanks the digits, clears the points and sets scan to digit 0.
// ----------------------------------------------------------------------------
module seven_segment_scan_formatter
(
    input  logic       clk,
    input  logic       rst_n,
    sssf_in_if.sink    req,
    sssf_out_if.source res
);
    import sssf_pkg::*;

    // chain[0] is the entry stage; chain[BIN_W] holds finished BCD digits
    item_t chain [BIN_W+1];
    logic  advance;

    // The whole chain moves together whenever the output register is free.
    assign req.ready = advance;

    // Magnitude and 9999 saturation, registered into the first link.
    sssf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .req_valid    (req.valid),
        .cmd          (req.cmd),
        .temp_centi   (req.temp_centi),
        .pressure_hpa (req.pressure_hpa),
        .item         (chain[0])
    );

    // One binary bit per cell, MSB first; after the last cell the bcd
    // field carries thousands..ones of the saturated value.
    for (genvar i = 0; i < BIN_W; i++)
    begin : g_cell
        sssf_dd_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (chain[i]),
            .item    (chain[i+1])
        );
    end

    // Format requests update the digit store here; scan ticks read it.
    sssf_display u_display
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (chain[BIN_W]),
        .advance (advance),
        .res     (res)
    );

endmodule

FILE: src/sssf_checker.sv
// ----------------------------------------------------------------------------
// sssf_checker
// Port-level checks on the formatter's result channel, bound to the top.
// ----------------------------------------------------------------------------
module sssf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [6:0] segments_n,
    input logic       point_n,
    input logic [3:0] digit_enable_n
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(segments_n) && $stable(point_n) && $stable(digit_enable_n))
        else $error("result payload changed while stalled");

    // exactly one anode driven per result
    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot(~digit_enable_n))
        else $error("digit enable not one-hot low");

    // the only point ever lit is on digit 2
    a_point_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !point_n |-> digit_enable_n == 4'b1011)
        else $error("decimal point lit off digit 2");

endmodule

bind seven_segment_scan_formatter sssf_checker u_sssf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .segments_n     (res.segments_n),
    .point_n        (res.point_n),
    .digit_enable_n (res.digit_enable_n)
);
